### rtl/core/bfm_pkg.sv
// Shared types, constants and register codes for the 3x3 mean filter.
package bfm_pkg;

  // Line store geometry and field widths.
  localparam int MAX_LINE = 1024;
  localparam int COL_W    = $clog2(MAX_LINE);
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = HEIGHT_W + 1;
  localparam int PIX_W    = 8;
  localparam int SUM_W    = 12;

  // Divide by nine as a multiply by a scaled reciprocal; exact for sums below 32768.
  localparam int MULT_W     = 13;
  localparam int PROD_W     = SUM_W + MULT_W;
  localparam int DIV9_SHIFT = 16;
  localparam logic [MULT_W-1:0] DIV9_MULT = 13'd7282;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RST   = 11'd640;
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [WIDTH_W-1:0]  MAX_LINE_W       = WIDTH_W'(MAX_LINE);

  typedef enum logic {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Input item function codes.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] sample;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic             frame_last;
  } res_item_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  line_width;
    logic [HEIGHT_W-1:0] frame_height;
  } cfg_t;

  // Per-item window control, settled when the item is accepted.
  typedef struct packed {
    logic emit;
    logic col_zero;
    logic left_ok;
    logic top_ok;
    logic bot_ok;
    logic last;
  } tap_ctl_t;

  typedef struct packed {
    logic             keep;
    tap_ctl_t         ctl;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] pix;
  } scan_t;

  // One line store word: the older and the newer of the two stored rows.
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

endpackage

### rtl/core/bfm_regs.sv
// Configuration register file behind the APB-style port.
module bfm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfm_pkg::APB_AW-1:0]  paddr,
  input  logic [bfm_pkg::APB_DW-1:0]  pwdata,
  output logic [bfm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output bfm_pkg::cfg_t               cfg
);
  import bfm_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width   <= LINE_WIDTH_RST;
      cfg.frame_height <= FRAME_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_LINE_WIDTH:   cfg.line_width   <= pwdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[HEIGHT_W-1:0];
      endcase
    end
  end

  // Read data is the addressed register, zero extended.
  always_comb begin
    unique case (idx)
      REG_LINE_WIDTH:   prdata = APB_DW'(cfg.line_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(cfg.frame_height);
    endcase
  end

endmodule

### rtl/core/bfm_scan.sv
// Raster position tracking and per-item border and emit control.
module bfm_scan (
  input  logic               clk,
  input  logic               rst,
  input  bfm_pkg::cfg_t      cfg,
  input  logic               take,
  input  bfm_pkg::pix_item_t item,
  output bfm_pkg::scan_t     scan
);
  import bfm_pkg::*;

  logic [COL_W-1:0]    in_column, in_column_next;
  logic [ROW_W-1:0]    in_row, in_row_next;
  logic [WIDTH_W-1:0]  cur_w, cfg_w, eff_w, col_inc;
  logic [HEIGHT_W-1:0] cur_h, cfg_h, eff_h;
  logic [ROW_W-1:0]    h_ext;
  logic                frame_start, in_frame, col_zero;

  // Clamp the programmed geometry to the supported range.
  always_comb begin
    cfg_w = cfg.line_width;
    if (cfg_w == '0) begin
      cfg_w = WIDTH_W'(1);
    end else if (cfg_w > MAX_LINE_W) begin
      cfg_w = MAX_LINE_W;
    end
    cfg_h = cfg.frame_height;
    if (cfg_h == '0) begin
      cfg_h = HEIGHT_W'(1);
    end
  end

  // A new frame picks up the current register values.
  assign frame_start = (in_row == '0) && (in_column == '0) && (item.func == FUNC_SAMPLE);
  assign eff_w       = frame_start ? cfg_w : cur_w;
  assign eff_h       = frame_start ? cfg_h : cur_h;
  assign h_ext       = ROW_W'(eff_h);
  assign in_frame    = in_row < h_ext;
  assign col_zero    = in_column == '0;

  // Control for the pixel whose result this item completes.
  always_comb begin
    scan.keep         = !((item.func == FUNC_DRAIN) && in_frame);
    scan.addr         = in_column;
    scan.pix          = in_frame ? item.sample : '0;
    scan.ctl.col_zero = col_zero;
    if (col_zero) begin
      scan.ctl.emit    = in_row >= ROW_W'(2);
      scan.ctl.left_ok = eff_w >= WIDTH_W'(2);
      scan.ctl.top_ok  = in_row >= ROW_W'(3);
      scan.ctl.bot_ok  = in_row <= h_ext;
      scan.ctl.last    = in_row == (h_ext + ROW_W'(1));
    end else begin
      scan.ctl.emit    = in_row >= ROW_W'(1);
      scan.ctl.left_ok = in_column >= COL_W'(2);
      scan.ctl.top_ok  = in_row >= ROW_W'(2);
      scan.ctl.bot_ok  = in_row < h_ext;
      scan.ctl.last    = 1'b0;
    end
  end

  // Next raster position; the frame's last result rewinds to the origin.
  always_comb begin
    col_inc        = WIDTH_W'(in_column) + WIDTH_W'(1);
    in_column_next = col_inc[COL_W-1:0];
    in_row_next    = in_row;
    if (col_inc >= eff_w) begin
      in_column_next = '0;
      in_row_next    = in_row + ROW_W'(1);
    end
    if (scan.ctl.last) begin
      in_column_next = '0;
      in_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      cur_w     <= LINE_WIDTH_RST;
      cur_h     <= FRAME_HEIGHT_RST;
    end else if (take && scan.keep) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      if (frame_start) begin
        cur_w <= cfg_w;
        cur_h <= cfg_h;
      end
    end
  end

endmodule

### rtl/core/bfm_line_buf.sv
// Two-row line store with registered read and same-cycle write forwarding.
module bfm_line_buf (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [bfm_pkg::COL_W-1:0]    rd_addr,
  input  logic                         wr_en,
  input  logic [bfm_pkg::COL_W-1:0]    wr_addr,
  input  bfm_pkg::line_pair_t          wr_data,
  output bfm_pkg::line_pair_t          rd_data
);
  import bfm_pkg::*;

  line_pair_t mem [MAX_LINE];
  line_pair_t mem_q, fwd_q;
  logic       fwd_sel;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a one-pixel line reads the word being written in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      fwd_q <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_sel <= 1'b0;
    end else if (rd_en) begin
      fwd_sel <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_sel ? fwd_q : mem_q;

endmodule

### rtl/core/bfm_window.sv
// 3x3 window registers and the border-substituted neighborhood sum.
module bfm_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift_en,
  input  bfm_pkg::tap_ctl_t           ctl,
  input  logic [bfm_pkg::PIX_W-1:0]   up,
  input  logic [bfm_pkg::PIX_W-1:0]   md,
  input  logic [bfm_pkg::PIX_W-1:0]   val,
  output logic [bfm_pkg::SUM_W-1:0]   sum
);
  import bfm_pkg::*;

  logic [PIX_W-1:0] win      [3][3];
  logic [PIX_W-1:0] win_next [3][3];
  logic [PIX_W-1:0] grid     [3][3];
  logic [PIX_W-1:0] col_in   [3];
  logic [PIX_W-1:0] ctr;

  assign col_in[0] = up;
  assign col_in[1] = md;
  assign col_in[2] = val;

  // Shift left by one column and load the new column on the right.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
      win_next[r][2] = col_in[r];
    end
  end

  // At a row start the window still holds the previous row's last pixel.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (ctl.col_zero) begin
        grid[r][0] = win[r][1];
        grid[r][1] = win[r][2];
        grid[r][2] = win[r][2];
      end else begin
        grid[r][0] = win_next[r][0];
        grid[r][1] = win_next[r][1];
        grid[r][2] = win_next[r][2];
      end
    end
  end

  // Taps outside the frame take the center sample.
  always_comb begin
    logic ok;
    ctr = grid[1][1];
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ok = 1'b1;
        if (r == 0 && !ctl.top_ok) ok = 1'b0;
        if (r == 2 && !ctl.bot_ok) ok = 1'b0;
        if (c == 0 && !ctl.left_ok) ok = 1'b0;
        if (c == 2 && ctl.col_zero) ok = 1'b0;
        sum = sum + SUM_W'(ok ? grid[r][c] : ctr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '{default: '{default: '0}};
    end else if (shift_en) begin
      win <= win_next;
    end
  end

endmodule

### rtl/core/box_filter_3x3_mean_top.sv
// Top level of the streaming 3x3 mean filter.
//
//   Channel   Signals                          Transaction
//   pixel     pix_valid, pix_ready, pix_data   one sample or drain tick
//   result    res_valid, res_ready, res_data   one mean value and frame-last flag
//   config    psel, penable, pwrite, paddr,    register write or read
//             pwdata, prdata, pready
//
// One pixel transaction is taken every clock cycle while pix_ready is high; the
// line store has one read and one write port and each item uses each once.
// A result passes the input, sum and result registers after the transaction that
// completes it, and results trail the samples by one row plus one pixel.
// Synchronous reset clears the pipeline and the raster position; the line
// store holds no reset state.
// A stalled result stage backs up through the pipeline to pix_ready.
module box_filter_3x3_mean_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_ready,
  input  bfm_pkg::pix_item_t          pix_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bfm_pkg::res_item_t          res_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfm_pkg::APB_AW-1:0]  paddr,
  input  logic [bfm_pkg::APB_DW-1:0]  pwdata,
  output logic [bfm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bfm_pkg::*;

  cfg_t             cfg;
  scan_t            scan;
  logic             pix_take;
  logic             s1_valid, s1_ready, s1_fire;
  tap_ctl_t         s1_ctl;
  logic [COL_W-1:0] s1_addr;
  logic [PIX_W-1:0] s1_pix;
  line_pair_t       rd_pair, wr_pair;
  logic [SUM_W-1:0] win_sum;
  logic             s2_valid, s2_ready, s2_fire, s2_last;
  logic [SUM_W-1:0] s2_sum;
  logic             out_free;
  logic [PROD_W-1:0] div_prod;

  bfm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow control: each stage advances when the next has room.
  assign out_free  = !res_valid || res_ready;
  assign s2_ready  = !s2_valid || out_free;
  assign s2_fire   = s2_valid && out_free;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s1_fire   = s1_valid && s2_ready;
  assign pix_ready = s1_ready;
  assign pix_take  = pix_valid && pix_ready;

  bfm_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (pix_take),
    .item (pix_data),
    .scan (scan)
  );

  // Input stage; an early drain tick leaves no item behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pix_take && scan.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      s1_ctl  <= scan.ctl;
      s1_addr <= scan.addr;
      s1_pix  <= scan.pix;
    end
  end

  // The middle row moves up and the new sample becomes the middle row.
  assign wr_pair.upper  = rd_pair.middle;
  assign wr_pair.middle = s1_pix;

  bfm_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (pix_take),
    .rd_addr (scan.addr),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr),
    .wr_data (wr_pair),
    .rd_data (rd_pair)
  );

  bfm_window u_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (s1_fire),
    .ctl      (s1_ctl),
    .up       (rd_pair.upper),
    .md       (rd_pair.middle),
    .val      (s1_pix),
    .sum      (win_sum)
  );

  // Sum stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_fire && s1_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_sum  <= win_sum;
      s2_last <= s1_ctl.last;
    end
  end

  // Truncated divide by nine through the scaled reciprocal.
  assign div_prod = PROD_W'(s2_sum) * PROD_W'(DIV9_MULT);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      res_data.mean_value <= div_prod[DIV9_SHIFT +: PIX_W];
      res_data.frame_last <= s2_last;
    end
  end

endmodule

### rtl/core/bfm_checker.sv
// Port-level checks for the 3x3 mean filter, bound to the top level.
module bfm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        pix_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input bfm_pkg::res_item_t          res_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [bfm_pkg::APB_AW-1:0]  paddr,
  input logic [bfm_pkg::APB_DW-1:0]  pwdata,
  input logic [bfm_pkg::APB_DW-1:0]  prdata,
  input logic                        pready
);
  import bfm_pkg::*;

  // A held result transaction keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // Reset empties the result stage.
  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // With the result stage free the whole pipeline can take a sample.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || res_ready) |-> pix_ready)
    else $error("input stalled while output is free");

  // A line width write reads back on the next read of that register.
  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && !pwrite && (paddr[APB_AW-1:2] == REG_LINE_WIDTH) &&
     $past(!rst && psel && penable && pwrite && pready &&
           (paddr[APB_AW-1:2] == REG_LINE_WIDTH)))
    |-> prdata[WIDTH_W-1:0] == $past(pwdata[WIDTH_W-1:0]))
    else $error("line width readback mismatch");

endmodule

bind box_filter_3x3_mean_top bfm_checker u_bfm_checker (.*);
